// ===== design/cti_pkg.sv =====
package cti_pkg;

	localparam int NPOS = 6;

	localparam logic [2:0] FN_LOAD    = 3'd0;
	localparam logic [2:0] FN_COMMIT  = 3'd1;
	localparam logic [2:0] FN_TICK    = 3'd2;
	localparam logic [2:0] FN_FINISH  = 3'd3;
	localparam logic [2:0] FN_RESTART = 3'd4;

	localparam logic REG_CYCLE = 1'b0;
	localparam logic REG_CTYPE = 1'b1;

	typedef struct packed {
		logic        [2:0]  func;
		logic        [2:0]  axis;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic        [15:0] segment_time_ms;
	} in_item_t;

	typedef struct packed {
		logic        [31:0] timestamp_ms;
		logic               kind;
		logic signed [31:0] pos_axis0;
		logic signed [31:0] pos_axis1;
		logic signed [31:0] pos_axis2;
		logic signed [31:0] pos_axis3;
		logic signed [31:0] pos_axis4;
		logic signed [31:0] pos_axis5;
		logic               segment_last;
		logic               final_point;
		logic               invalid_segment;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SDIV, ST_SQ, ST_CU, ST_W0M, ST_W0D, ST_W1M, ST_W1D,
		ST_A1, ST_A2, ST_A3, ST_FIN, ST_OUT
	} state_t;

endpackage

// ===== design/cti_if.sv =====
interface cti_in_if;
	import cti_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cti_out_if;
	import cti_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/cubic_trajectory_interpolator_top.sv =====
// Six-axis cubic Hermite trajectory sampler. One item is handled at a time: load,
// commit, restart and items that give no result complete on acceptance; finish
// loads the result and then waits for the output handshake. A tick runs through
// one shared bit-serial shift-add multiplier and one restoring divider: the
// divider gives the curve parameter and the multiplier its square and cube, then
// per axis both velocities are multiplied by the segment time and divided by
// 1000, and three products are summed into the new position.
// Positions are Q16.16, velocities Q16.16 per second.
module cubic_trajectory_interpolator_top
	import cti_pkg::*;
#(
	parameter int AXES = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [4:0] cfg_wdata,
	cti_in_if.sink     req,
	cti_out_if.source  rsp
);
	localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int NP = (AXES > NPOS) ? AXES : NPOS;
	localparam logic [5:0] MUL_LAST = 6'd29;
	localparam logic [5:0] DIV_LAST = 6'd49;

	state_t state_q, state_d;

	logic [4:0]         cycle_q;
	logic               ctype_q;
	logic signed [31:0] stg_pos_q [AXES];
	logic signed [31:0] stg_vel_q [AXES];
	logic signed [31:0] st_pos_q  [AXES];
	logic signed [31:0] st_vel_q  [AXES];
	logic signed [31:0] en_pos_q  [AXES];
	logic signed [31:0] en_vel_q  [AXES];
	logic signed [31:0] pos_q     [NP];
	logic [15:0]        stg_time_q, seg_time_q, end_time_q, idx_q, t_q;
	logic [31:0]        tick_q, stamp_q;
	logic [1:0]         held_q;
	logic               active_q, last_q, inv_q, final_q;

	logic [AW-1:0]      ax_q;
	logic [24:0]        s_q, s2_q, s3_q;
	logic signed [47:0] wp_q;
	logic signed [39:0] w0_q, w1_q;
	logic signed [63:0] acc_q;
	logic [5:0]         cnt_q;
	logic [63:0]        mc_q, prod_q;
	logic [27:0]        mp_q;
	logic               mneg_q;
	logic [15:0]        rem_q;
	logic [47:0]        qq_q;
	logic               dneg_q;

	logic               acc_in, is_mul, is_div, done;
	logic signed [49:0] ma;
	logic signed [27:0] mb;
	logic signed [27:0] h01, h10, h11;
	logic signed [63:0] mres, p_round;
	logic [15:0]        dvs;
	logic [16:0]        rtmp;
	logic               rge;
	logic [20:0]        t_full;
	logic [21:0]        t_next;
	logic [36:0]        stamp_full;
	logic [63:0]        rmag;
	logic signed [32:0] dlt;

	assign acc_in = req.valid && req.ready;

	always_comb begin
		h01 = 28'(3 * $signed({3'b0, s2_q})) - 28'(2 * $signed({3'b0, s3_q}));
		h10 = $signed({3'b0, s_q}) - 28'(2 * $signed({3'b0, s2_q})) + $signed({3'b0, s3_q});
		h11 = $signed({3'b0, s3_q}) - $signed({3'b0, s2_q});
		dlt = 33'(en_pos_q[ax_q]) - 33'(st_pos_q[ax_q]);
		ma = '0;
		mb = '0;
		case (state_q)
			ST_SQ: begin
				ma = 50'(s_q);
				mb = 28'(s_q);
			end
			ST_CU: begin
				ma = 50'(s2_q);
				mb = 28'(s_q);
			end
			ST_W0M: begin
				ma = 50'(st_vel_q[ax_q]);
				mb = 28'(seg_time_q);
			end
			ST_W1M: begin
				ma = 50'(en_vel_q[ax_q]);
				mb = 28'(seg_time_q);
			end
			ST_A1: begin
				ma = 50'(dlt);
				mb = h01;
			end
			ST_A2: begin
				ma = 50'(w0_q);
				mb = h10;
			end
			ST_A3: begin
				ma = 50'(w1_q);
				mb = h11;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		mres = mneg_q ? -$signed(prod_q) : $signed(prod_q);
		dvs  = (state_q == ST_SDIV) ? seg_time_q : 16'd1000;
		rtmp = {rem_q, qq_q[47]};
		rge  = rtmp >= {1'b0, dvs};
		rmag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
		p_round = 64'(st_pos_q[ax_q]) + (acc_q[63] ? -$signed(64'((rmag + 64'd8388608) >> 24))
			: $signed(64'((rmag + 64'd8388608) >> 24)));
		t_full = 21'(idx_q) * 21'(cycle_q);
		t_next = (22'(idx_q) + 22'd1) * 22'(cycle_q);
		stamp_full = 37'(tick_q) * 37'(cycle_q);
	end

	always_comb begin
		is_mul = (state_q == ST_SQ) || (state_q == ST_CU) || (state_q == ST_W0M) ||
			(state_q == ST_W1M) || (state_q == ST_A1) || (state_q == ST_A2) ||
			(state_q == ST_A3);
		is_div = (state_q == ST_SDIV) || (state_q == ST_W0D) || (state_q == ST_W1D);
		done = (is_mul && cnt_q == MUL_LAST) || (is_div && cnt_q == DIV_LAST);
		req.ready = (state_q == ST_IDLE);
		rsp.valid = (state_q == ST_OUT);
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_in && req.data.func == FN_TICK && active_q)
					state_d = ST_SDIV;
				else if (acc_in && req.data.func == FN_FINISH && held_q != 2'd0)
					state_d = ST_OUT;
			end
			ST_SDIV: if (done) state_d = ST_SQ;
			ST_SQ:   if (done) state_d = ST_CU;
			ST_CU:   if (done) state_d = ST_W0M;
			ST_W0M:  if (done) state_d = ST_W0D;
			ST_W0D:  if (done) state_d = ST_W1M;
			ST_W1M:  if (done) state_d = ST_W1D;
			ST_W1D:  if (done) state_d = ST_A1;
			ST_A1:   if (done) state_d = ST_A2;
			ST_A2:   if (done) state_d = ST_A3;
			ST_A3:   if (done) state_d = ST_FIN;
			ST_FIN:  state_d = (32'(ax_q) == AXES - 1) ? ST_OUT : ST_W0M;
			ST_OUT:  if (rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q <= 5'd1;
			ctype_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				stg_pos_q[i] <= '0;
				stg_vel_q[i] <= '0;
				st_pos_q[i]  <= '0;
				st_vel_q[i]  <= '0;
				en_pos_q[i]  <= '0;
				en_vel_q[i]  <= '0;
			end
			for (int i = 0; i < NP; i++) pos_q[i] <= '0;
			stg_time_q <= '0;
			seg_time_q <= '0;
			end_time_q <= '0;
			idx_q      <= '0;
			tick_q     <= '0;
			held_q     <= '0;
			active_q   <= 1'b0;
			cnt_q      <= '0;
			ax_q       <= '0;
			stamp_q    <= '0;
			t_q        <= '0;
			last_q     <= 1'b0;
			inv_q      <= 1'b0;
			final_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_CYCLE)
					cycle_q <= (cfg_wdata == 5'd0) ? 5'd1 : (cfg_wdata > 5'd16) ? 5'd16 : cfg_wdata;
				else if (cfg_idx == REG_CTYPE)
					ctype_q <= cfg_wdata[0];
			end
			if (acc_in) begin
				case (req.data.func)
					FN_LOAD: begin
						if (32'(req.data.axis) < AXES) begin
							stg_pos_q[req.data.axis[AW-1:0]] <= req.data.position;
							stg_vel_q[req.data.axis[AW-1:0]] <= req.data.velocity;
							stg_time_q <= req.data.segment_time_ms;
						end
					end
					FN_COMMIT: begin
						for (int i = 0; i < AXES; i++) begin
							st_pos_q[i] <= en_pos_q[i];
							st_vel_q[i] <= en_vel_q[i];
							en_pos_q[i] <= stg_pos_q[i];
							en_vel_q[i] <= stg_vel_q[i];
						end
						seg_time_q <= end_time_q;
						end_time_q <= stg_time_q;
						held_q   <= (held_q == 2'd2) ? 2'd2 : held_q + 2'd1;
						active_q <= (held_q != 2'd0);
						idx_q    <= '0;
					end
					FN_RESTART: begin
						held_q   <= '0;
						active_q <= 1'b0;
						idx_q    <= '0;
						tick_q   <= '0;
					end
					FN_TICK: begin
						if (active_q) begin
							stamp_q <= (stamp_full[36:32] != 5'd0) ? '1 : stamp_full[31:0];
							t_q     <= (t_full > 21'(seg_time_q)) ? seg_time_q : t_full[15:0];
							last_q  <= t_next >= 22'(seg_time_q);
							inv_q   <= (seg_time_q == 16'd0);
							final_q <= 1'b0;
							ax_q    <= '0;
							if (tick_q != '1) tick_q <= tick_q + 32'd1;
							if (t_next >= 22'(seg_time_q)) active_q <= 1'b0;
							else idx_q <= idx_q + 16'd1;
						end
					end
					FN_FINISH: begin
						if (held_q != 2'd0) begin
							stamp_q <= (stamp_full[36:32] != 5'd0) ? '1 : stamp_full[31:0];
							last_q  <= 1'b0;
							inv_q   <= 1'b0;
							final_q <= 1'b1;
							active_q <= 1'b0;
							for (int i = 0; i < AXES; i++) pos_q[i] <= en_pos_q[i];
						end
					end
					default: ;
				endcase
			end
			if (is_mul || is_div) cnt_q <= done ? 6'd0 : cnt_q + 6'd1;
			if (state_q == ST_FIN) begin
				pos_q[ax_q] <= (p_round > 64'sd2147483647) ? 32'sh7FFFFFFF :
					(p_round < -64'sd2147483648) ? 32'sh80000000 : p_round[31:0];
				ax_q <= ax_q + AW'(1);
			end
		end
	end

	// shared serial multiplier and divider
	always_ff @(posedge clk) begin
		if (is_mul) begin
			if (cnt_q == 6'd0) begin
				mc_q   <= 64'(ma[49] ? -ma : ma);
				mp_q   <= mb[27] ? 28'(-mb) : 28'(mb);
				prod_q <= '0;
				mneg_q <= ma[49] ^ mb[27];
			end else if (cnt_q != MUL_LAST) begin
				prod_q <= prod_q + (mp_q[0] ? mc_q : 64'd0);
				mc_q   <= mc_q << 1;
				mp_q   <= mp_q >> 1;
			end else begin
				case (state_q)
					ST_SQ:   s2_q  <= 25'((prod_q + 64'd8388608) >> 24);
					ST_CU:   s3_q  <= 25'((prod_q + 64'd8388608) >> 24);
					ST_W0M:  wp_q  <= mres[47:0];
					ST_W1M:  wp_q  <= mres[47:0];
					ST_A1:   acc_q <= mres;
					ST_A2:   acc_q <= acc_q + mres;
					ST_A3:   acc_q <= acc_q + mres;
					default: ;
				endcase
			end
		end
		if (is_div) begin
			if (cnt_q == 6'd0) begin
				rem_q <= '0;
				if (state_q == ST_SDIV) begin
					qq_q   <= {8'd0, t_q, 24'd0};
					dneg_q <= 1'b0;
				end else begin
					qq_q   <= (wp_q[47] ? 48'(-wp_q) : 48'(wp_q)) + 48'd500;
					dneg_q <= wp_q[47];
				end
			end else if (cnt_q != DIV_LAST) begin
				rem_q <= rge ? 16'(rtmp - {1'b0, dvs}) : rtmp[15:0];
				qq_q  <= {qq_q[46:0], rge};
			end else begin
				case (state_q)
					ST_SDIV: s_q <= (seg_time_q == 16'd0) ? 25'd0 :
						(qq_q > 48'd16777216) ? 25'd16777216 : qq_q[24:0];
					ST_W0D:  w0_q <= dneg_q ? -$signed(qq_q[39:0]) : $signed(qq_q[39:0]);
					ST_W1D:  w1_q <= dneg_q ? -$signed(qq_q[39:0]) : $signed(qq_q[39:0]);
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		rsp.data.timestamp_ms    = stamp_q;
		rsp.data.kind            = ctype_q;
		rsp.data.pos_axis0       = pos_q[0];
		rsp.data.pos_axis1       = pos_q[1];
		rsp.data.pos_axis2       = pos_q[2];
		rsp.data.pos_axis3       = pos_q[3];
		rsp.data.pos_axis4       = pos_q[4];
		rsp.data.pos_axis5       = pos_q[5];
		rsp.data.segment_last    = last_q;
		rsp.data.final_point     = final_q;
		rsp.data.invalid_segment = inv_q;
	end

	a_held: assert property (@(posedge clk) disable iff (!arst_n) held_q != 2'd3)
		else $error("held count out of range");
	a_active: assert property (@(posedge clk) disable iff (!arst_n) active_q |-> held_q == 2'd2)
		else $error("segment active without two waypoints");
	a_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		cycle_q != 5'd0 && cycle_q <= 5'd16)
		else $error("cycle period out of range");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(pos_q[0]))
		else $error("result changed while waiting");
endmodule
